FILE: rtl/sqfs_pkg.sv
// Package: shared types and defaults for the swap queue fit selector.
package sqfs_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int PID_W           = 16;
	localparam int SIZE_W          = 32;
	localparam int OCC_W           = 5;

	typedef enum logic {
		OP_APPEND   = 1'b0,
		OP_RETRIEVE = 1'b1
	} opcode_t;

	typedef enum logic {
		FIT_FIRST = 1'b0,
		FIT_BEST  = 1'b1
	} fit_policy_t;

	typedef struct packed {
		logic [PID_W-1:0]  pid;
		logic [SIZE_W-1:0] size;
		logic              blocked;
	} entry_t;

	typedef struct packed {
		logic              have;
		logic [SIZE_W-1:0] size;
		logic [PID_W-1:0]  pid;
	} scan_t;

	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctrl_t;

	typedef struct packed {
		logic [SIZE_W-1:0] avail;
		logic              allow;
		fit_policy_t       policy;
	} scan_ops_t;

endpackage

FILE: rtl/swap_queue_fit_select.sv
// Top level: swap queue with first-fit and best-fit retrieve over a chain of slot cells.
// An append finishes at once: its result strobes on done in the cycle after the
// accepting edge and busy stays low. A retrieve raises busy while the FSM runs
// through its scan and apply states, and its result strobes on done as the FSM leaves
// the apply state; the selection token walks the cell chain one slot per cycle.
// Each result strobes done for exactly one cycle, and the strobe cannot be held.
module swap_queue_fit_select
	import sqfs_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fit_policy_we,
	input  logic              fit_policy_wdata,
	input  logic              start,
	output logic              busy,
	input  logic              opcode,
	input  logic [PID_W-1:0]  proc_id,
	input  logic [SIZE_W-1:0] proc_size,
	input  logic              proc_blocked,
	input  logic [SIZE_W-1:0] size_available,
	input  logic              allow_blocked,
	output logic              done,
	output logic              found,
	output logic [PID_W-1:0]  out_pid,
	output logic              full_error,
	output logic [OCC_W-1:0]  occupancy
);

	localparam int IW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] Depth   = CW'(QUEUE_DEPTH);
	localparam logic [IW-1:0] LastCnt = IW'(QUEUE_DEPTH - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_APPLY
	} state_t;

	state_t            state_q;
	logic [IW-1:0]     cnt_q;
	logic [CW-1:0]     count_q;
	fit_policy_t       policy_q;
	scan_ops_t         ops_q;
	logic              done_q;
	logic              found_q;
	logic [PID_W-1:0]  pid_q;
	logic              full_q;

	logic              accept;
	logic              do_append;
	logic              do_shift;
	entry_t            new_ent;
	entry_t            ents      [QUEUE_DEPTH];
	scan_t             scan_chain[QUEUE_DEPTH+1];
	logic [IW-1:0]     idx_chain [QUEUE_DEPTH+1];
	scan_t             sel;
	logic [IW-1:0]     sel_idx;

	assign accept    = start && (state_q == ST_IDLE);
	assign do_append = accept && (opcode_t'(opcode) == OP_APPEND) && (count_q < Depth);
	assign sel       = scan_chain[QUEUE_DEPTH];
	assign sel_idx   = idx_chain[QUEUE_DEPTH];
	assign do_shift  = (state_q == ST_APPLY) && sel.have;
	assign new_ent   = '{pid: proc_id, size: proc_size, blocked: proc_blocked};

	assign scan_chain[0] = '0;
	assign idx_chain[0]  = '0;

	for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
		cell_ctrl_t ctrl;
		entry_t     nxt;
		logic       valid;

		assign valid = CW'(k) < count_q;
		assign ctrl  = '{load: do_append && (CW'(k) == count_q),
			shift: do_shift && (IW'(k) >= sel_idx)};
		if (k < QUEUE_DEPTH - 1) begin : g_mid
			assign nxt = ents[k+1];
		end else begin : g_last
			assign nxt = ents[k];
		end

		sqfs_cell #(
			.IDX_W   (IW),
			.CELL_IDX(k)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (ctrl),
			.valid   (valid),
			.load_ent(new_ent),
			.next_ent(nxt),
			.ops     (ops_q),
			.scan_in (scan_chain[k]),
			.idx_in  (idx_chain[k]),
			.ent     (ents[k]),
			.scan_out(scan_chain[k+1]),
			.idx_out (idx_chain[k+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= FIT_FIRST;
		end else if (fit_policy_we) begin
			policy_q <= fit_policy_t'(fit_policy_wdata);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ops_q <= '{avail: size_available, allow: allow_blocked, policy: policy_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
			found_q <= 1'b0;
			pid_q   <= '0;
			full_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (opcode_t'(opcode) == OP_APPEND) begin
							done_q  <= 1'b1;
							found_q <= 1'b0;
							pid_q   <= '0;
							full_q  <= !do_append;
							if (do_append) begin
								count_q <= count_q + CW'(1);
							end
						end else begin
							cnt_q   <= '0;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + IW'(1);
					if (cnt_q == LastCnt) begin
						state_q <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					done_q  <= 1'b1;
					found_q <= sel.have;
					pid_q   <= sel.have ? sel.pid : '0;
					full_q  <= 1'b0;
					if (sel.have) begin
						count_q <= count_q - CW'(1);
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy       = (state_q != ST_IDLE);
	assign done       = done_q;
	assign found      = found_q;
	assign out_pid    = pid_q;
	assign full_error = full_q;
	assign occupancy  = OCC_W'(count_q);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= Depth)
		else $error("entry count above depth");

	a_found_only_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && found_q) |-> !full_q)
		else $error("found without a retrieve result");

	a_full_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && full_q) |-> (count_q == Depth))
		else $error("append refused while queue had room");

	a_found_drops_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && found_q) |-> ((count_q + CW'(1)) == $past(count_q)))
		else $error("removal did not drop the entry count");

	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(state_q) == ST_APPLY) || $past(accept))
		else $error("result without an item");

endmodule

FILE: rtl/sqfs_cell.sv
// One queue slot: holds an entry and passes the running selection to its neighbor.
module sqfs_cell
	import sqfs_pkg::*;
#(
	parameter int IDX_W    = 4,
	parameter int CELL_IDX = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cell_ctrl_t       ctrl,
	input  logic             valid,
	input  entry_t           load_ent,
	input  entry_t           next_ent,
	input  scan_ops_t        ops,
	input  scan_t            scan_in,
	input  logic [IDX_W-1:0] idx_in,
	output entry_t           ent,
	output scan_t            scan_out,
	output logic [IDX_W-1:0] idx_out
);

	localparam logic [IDX_W-1:0] MyIdx = IDX_W'(CELL_IDX);

	entry_t           ent_q;
	scan_t            scan_q;
	logic [IDX_W-1:0] idx_q;
	logic             qual;
	logic             take;

	assign qual = valid && (!ent_q.blocked || ops.allow) && (ent_q.size <= ops.avail);
	assign take = qual && (!scan_in.have ||
		((ops.policy == FIT_BEST) && (ent_q.size < scan_in.size)));

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			ent_q <= load_ent;
		end else if (ctrl.shift) begin
			ent_q <= next_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
			idx_q  <= '0;
		end else if (take) begin
			scan_q <= '{have: 1'b1, size: ent_q.size, pid: ent_q.pid};
			idx_q  <= MyIdx;
		end else begin
			scan_q <= scan_in;
			idx_q  <= idx_in;
		end
	end

	assign ent      = ent_q;
	assign scan_out = scan_q;
	assign idx_out  = idx_q;

endmodule
